### rtl/core/svfm_pkg.sv
package svfm_pkg;

  // Field and register widths
  localparam int SampleW  = 24;
  localparam int CoefW    = 24;
  localparam int MixW     = 16;
  localparam int ThW      = 23;
  localparam int CgW      = 17;
  localparam int IntW     = 32;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 24;

  // Shared multiplier: A operand is split into two chunks of ChunkW bits
  localparam int ChunkW = 20;
  localparam int OpAW   = 2 * ChunkW;
  localparam int OpBW   = 25;
  localparam int ProdW  = ChunkW + 1 + OpBW;
  localparam int AccW   = 66;

  // Reset values of the configuration registers
  localparam logic [CoefW-1:0] CutoffReset = 24'd1048576;
  localparam logic [CoefW-1:0] DampReset   = 24'd5931642;
  localparam logic [CoefW-1:0] NormReset   = 24'd4194304;
  localparam logic [MixW-1:0]  MixLowReset = 16'd16384;
  localparam logic [MixW-1:0]  MixBandReset = 16'd0;
  localparam logic [MixW-1:0]  MixHighReset = 16'd0;
  localparam logic [ThW-1:0]   ThReset     = 23'd8388607;
  localparam logic [CgW-1:0]   CgReset     = 17'd65536;

  localparam logic signed [AccW-1:0] Max32 = 66'sd2147483647;
  localparam logic signed [AccW-1:0] Min32 = -66'sd2147483648;
  localparam logic signed [AccW-1:0] Max24 = 66'sd8388607;
  localparam logic signed [AccW-1:0] Min24 = -66'sd8388608;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CUTOFF_GAIN    = 4'd0,
    REG_DAMPING        = 4'd1,
    REG_NORM_GAIN      = 4'd2,
    REG_MIX_LOW        = 4'd3,
    REG_MIX_BAND       = 4'd4,
    REG_MIX_HIGH       = 4'd5,
    REG_CLIP_THRESHOLD = 4'd6,
    REG_CLIP_GAIN      = 4'd7
  } cfg_reg_e;

  // One product per operation, in execution order
  typedef enum logic [2:0] {
    OP_CLIP,
    OP_BP_PRE,
    OP_BP,
    OP_LP,
    OP_DAMP,
    OP_MIX_LOW,
    OP_MIX_BAND,
    OP_MIX_HIGH
  } op_e;

  typedef enum logic [1:0] {
    PH_LO,
    PH_HI,
    PH_DRAIN,
    PH_WB
  } phase_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } fsm_e;

  typedef struct packed {
    logic   ready;
    logic   busy;
    op_e    op;
    phase_e phase;
    logic   done;
  } seq_ctrl_t;

  // Half an LSB of the rescale shift that follows each operation
  function automatic logic signed [AccW-1:0] op_round(input op_e op);
    logic signed [AccW-1:0] r;
    case (op)
      OP_CLIP:                       r = 66'sd32768;
      OP_BP_PRE, OP_LP:              r = 66'sd524288;
      OP_BP, OP_DAMP:                r = 66'sd2097152;
      OP_MIX_LOW, OP_MIX_BAND,
      OP_MIX_HIGH:                   r = 66'sd8192;
      default:                       r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [IntW-1:0] sat32(input logic signed [AccW-1:0] x);
    logic signed [IntW-1:0] r;
    if (x > Max32) begin
      r = Max32[IntW-1:0];
    end else if (x < Min32) begin
      r = Min32[IntW-1:0];
    end else begin
      r = x[IntW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SampleW-1:0] sat24(input logic signed [AccW-1:0] x);
    logic signed [SampleW-1:0] r;
    if (x > Max24) begin
      r = Max24[SampleW-1:0];
    end else if (x < Min24) begin
      r = Min24[SampleW-1:0];
    end else begin
      r = x[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/state_variable_filter_morph.sv
// Soft clip followed by a trapezoidal two-integrator state variable filter
// with a morphing low/band/high mix, for up to NUM_CHANNELS interleaved audio
// channels. Each sample (tdata, signed Q1.23) arrives with its channel number
// (tuser); the result carries the same channel number back on tuser. The
// channel selects the band and low integrator pair; numbers at or beyond
// NUM_CHANNELS wrap modulo NUM_CHANNELS. All arithmetic runs on one shared
// 21x25 multiplier: each sample takes eight products (clip slope, g*(v0-ic2),
// norm, g*v1, k*v1 and the three mix weights), each product in four phases
// (low chunk, high chunk, accumulate, write-back). The last write-back of a
// transaction waits while a previous result has not yet been taken
// downstream; then the result is registered on the output and the sequencer
// goes idle, so a new sample is never taken while one is still in progress.
// A new sample is taken as soon as the sequencer is idle, even while a
// finished result still waits on the output. Coefficients (tan, 1/Q, the
// normalizing gain, mix weights) are precomputed by software; the user must
// write them on the configuration channel between samples, which the block
// does not enforce. Writes beyond the register list are dropped. v1, v2 and
// the integrators saturate to 32 bits, the clipped input and output to 24 bits.
module state_variable_filter_morph #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [svfm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [svfm_pkg::CfgDataW-1:0]  cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // [23:0] sample_in
  input  logic                           s_axis_tuser,  // [0] channel_num
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,  // [23:0] sample_out
  output logic                           m_axis_tuser   // [0] channel_out
);

  localparam int ChIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int AccW   = svfm_pkg::AccW;
  localparam int OpAW   = svfm_pkg::OpAW;
  localparam int OpBW   = svfm_pkg::OpBW;
  localparam int IntW   = svfm_pkg::IntW;
  localparam int SW     = svfm_pkg::SampleW;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [svfm_pkg::CoefW-1:0]       cutoff_q, damp_q, norm_q;
  logic signed [svfm_pkg::MixW-1:0] mix_low_q, mix_band_q, mix_high_q;
  logic [svfm_pkg::ThW-1:0]         th_q;
  logic [svfm_pkg::CgW-1:0]         cg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q   <= svfm_pkg::CutoffReset;
      damp_q     <= svfm_pkg::DampReset;
      norm_q     <= svfm_pkg::NormReset;
      mix_low_q  <= svfm_pkg::MixLowReset;
      mix_band_q <= svfm_pkg::MixBandReset;
      mix_high_q <= svfm_pkg::MixHighReset;
      th_q       <= svfm_pkg::ThReset;
      cg_q       <= svfm_pkg::CgReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        svfm_pkg::REG_CUTOFF_GAIN:    cutoff_q   <= cfg_data_i;
        svfm_pkg::REG_DAMPING:        damp_q     <= cfg_data_i;
        svfm_pkg::REG_NORM_GAIN:      norm_q     <= cfg_data_i;
        svfm_pkg::REG_MIX_LOW:        mix_low_q  <= cfg_data_i[svfm_pkg::MixW-1:0];
        svfm_pkg::REG_MIX_BAND:       mix_band_q <= cfg_data_i[svfm_pkg::MixW-1:0];
        svfm_pkg::REG_MIX_HIGH:       mix_high_q <= cfg_data_i[svfm_pkg::MixW-1:0];
        svfm_pkg::REG_CLIP_THRESHOLD: th_q       <= cfg_data_i[svfm_pkg::ThW-1:0];
        svfm_pkg::REG_CLIP_GAIN:      cg_q       <= cfg_data_i[svfm_pkg::CgW-1:0];
        default: ;  // drop writes to unknown indices
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  svfm_pkg::seq_ctrl_t ctrl;
  logic                out_valid_q;
  logic                out_free;
  logic                start;
  logic                wb;

  assign out_free = !out_valid_q || m_axis_tready;

  svfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  assign s_axis_tready = ctrl.ready;
  assign start         = ctrl.ready && s_axis_tvalid;
  // write-back of every product except the last, which waits for done
  assign wb = ctrl.busy && (ctrl.phase == svfm_pkg::PH_WB)
           && (ctrl.op != svfm_pkg::OP_MIX_HIGH);

  // ---------------------------------------------------------------------
  // Integrator state, one pair per channel
  // ---------------------------------------------------------------------
  logic signed [IntW-1:0] band_q [NUM_CHANNELS];
  logic signed [IntW-1:0] low_q  [NUM_CHANNELS];
  logic [ChIdxW-1:0]      in_idx;

  assign in_idx = (NUM_CHANNELS > 1) ? ChIdxW'(s_axis_tuser) : '0;

  // ---------------------------------------------------------------------
  // Per-sample working registers
  // ---------------------------------------------------------------------
  logic signed [SW-1:0]   x_q;
  logic                   chan_q;
  logic [ChIdxW-1:0]      idx_q;
  logic signed [IntW-1:0] ic1_q, ic2_q;
  logic signed [SW-1:0]   v0_q;
  logic signed [OpAW-1:0] t_q;
  logic signed [IntW-1:0] v1_q, v2_q;
  logic signed [OpAW-1:0] hp_q;
  logic signed [SW-1:0]   out_data_q;
  logic                   out_user_q;

  // ---------------------------------------------------------------------
  // Operand selection for the shared multiplier
  // ---------------------------------------------------------------------
  logic signed [SW:0]     xe, the, clip_diff;
  logic                   over, under;
  logic signed [IntW:0]   v0_minus_ic2;
  logic signed [OpAW-1:0] op_a;
  logic signed [OpBW-1:0] op_b;
  logic                   clear;
  logic signed [AccW-1:0] acc;

  assign xe        = (SW + 1)'(x_q);
  assign the       = $signed({2'b00, th_q});
  assign over      = xe > the;
  assign under     = xe < -the;
  assign clip_diff = over ? (xe - the) : (xe + the);
  assign v0_minus_ic2 = (IntW + 1)'(v0_q) - (IntW + 1)'(ic2_q);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.op)
      svfm_pkg::OP_CLIP: begin
        op_a = OpAW'(clip_diff);
        op_b = OpBW'($signed({1'b0, cg_q}));
      end
      svfm_pkg::OP_BP_PRE: begin
        op_a = OpAW'(v0_minus_ic2);
        op_b = OpBW'($signed({1'b0, cutoff_q}));
      end
      svfm_pkg::OP_BP: begin
        op_a = t_q;
        op_b = OpBW'($signed({1'b0, norm_q}));
      end
      svfm_pkg::OP_LP: begin
        op_a = OpAW'(v1_q);
        op_b = OpBW'($signed({1'b0, cutoff_q}));
      end
      svfm_pkg::OP_DAMP: begin
        op_a = OpAW'(v1_q);
        op_b = OpBW'($signed({1'b0, damp_q}));
      end
      svfm_pkg::OP_MIX_LOW: begin
        op_a = OpAW'(v2_q);
        op_b = OpBW'(mix_low_q);
      end
      svfm_pkg::OP_MIX_BAND: begin
        op_a = OpAW'(v1_q);
        op_b = OpBW'(mix_band_q);
      end
      svfm_pkg::OP_MIX_HIGH: begin
        op_a = hp_q;
        op_b = OpBW'(mix_high_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // the three mix products accumulate into one sum
  assign clear = (ctrl.op != svfm_pkg::OP_MIX_BAND) && (ctrl.op != svfm_pkg::OP_MIX_HIGH);

  svfm_mac u_mac (
    .clk_i   (clk_i),
    .phase_i (ctrl.phase),
    .clear_i (clear),
    .rnd_i   (svfm_pkg::op_round(ctrl.op)),
    .a_i     (op_a),
    .b_i     (op_b),
    .acc_o   (acc)
  );

  // ---------------------------------------------------------------------
  // Write-back: rescale (rounding already preloaded), add, saturate
  // ---------------------------------------------------------------------
  logic signed [AccW-1:0] r14, r16, r20, r22;
  logic signed [AccW-1:0] clip_sum;

  assign r14 = acc >>> 14;
  assign r16 = acc >>> 16;
  assign r20 = acc >>> 20;
  assign r22 = acc >>> 22;

  always_comb begin
    if (over) begin
      clip_sum = AccW'(the) + r16;
    end else if (under) begin
      clip_sum = r16 - AccW'(the);
    end else begin
      clip_sum = AccW'(xe);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      x_q    <= s_axis_tdata;
      chan_q <= s_axis_tuser;
      idx_q  <= in_idx;
      ic1_q  <= band_q[in_idx];
      ic2_q  <= low_q[in_idx];
    end
    if (wb) begin
      case (ctrl.op)
        svfm_pkg::OP_CLIP:   v0_q <= svfm_pkg::sat24(clip_sum);
        svfm_pkg::OP_BP_PRE: t_q  <= OpAW'(AccW'(ic1_q) + r20);
        svfm_pkg::OP_BP:     v1_q <= svfm_pkg::sat32(r22);
        svfm_pkg::OP_LP:     v2_q <= svfm_pkg::sat32(AccW'(ic2_q) + r20);
        svfm_pkg::OP_DAMP:   hp_q <= OpAW'(AccW'(v0_q) - r22 - AccW'(v2_q));
        default: ;  // mix products only accumulate
      endcase
    end
    if (ctrl.done) begin
      out_data_q <= svfm_pkg::sat24(r14);
      out_user_q <= chan_q;
    end
  end

  // Integrators: clear on reset, update when the sample completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        band_q[i] <= '0;
        low_q[i]  <= '0;
      end
    end else if (ctrl.done) begin
      band_q[idx_q] <= svfm_pkg::sat32((AccW'(v1_q) <<< 1) - AccW'(ic1_q));
      low_q[idx_q]  <= svfm_pkg::sat32((AccW'(v2_q) <<< 1) - AccW'(ic2_q));
    end
  end

  // ---------------------------------------------------------------------
  // Output register: hold the result until the downstream side takes it
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

### rtl/core/svfm_mac.sv
// Shared multiply-accumulate unit: one 21x25 signed multiplier, product
// registered, then accumulated with the chunk weight.
module svfm_mac (
  input  logic                                  clk_i,
  input  svfm_pkg::phase_e                      phase_i,
  input  logic                                  clear_i,
  input  logic signed [svfm_pkg::AccW-1:0]      rnd_i,
  input  logic signed [svfm_pkg::OpAW-1:0]      a_i,
  input  logic signed [svfm_pkg::OpBW-1:0]      b_i,
  output logic signed [svfm_pkg::AccW-1:0]      acc_o
);

  logic signed [svfm_pkg::ChunkW:0]     chunk;
  logic signed [svfm_pkg::ProdW-1:0]    prod;
  logic signed [svfm_pkg::ProdW-1:0]    p_q;
  logic signed [svfm_pkg::AccW-1:0]     p_ext;
  logic signed [svfm_pkg::AccW-1:0]     acc_d, acc_q;

  // Low chunk is unsigned, high chunk carries the sign
  assign chunk = (phase_i == svfm_pkg::PH_LO)
               ? $signed({1'b0, a_i[svfm_pkg::ChunkW-1:0]})
               : $signed({a_i[svfm_pkg::OpAW-1], a_i[svfm_pkg::OpAW-1:svfm_pkg::ChunkW]});
  assign prod  = chunk * b_i;
  assign p_ext = svfm_pkg::AccW'(p_q);

  always_comb begin
    acc_d = acc_q;
    case (phase_i)
      svfm_pkg::PH_LO:    acc_d = clear_i ? rnd_i : acc_q;
      svfm_pkg::PH_HI:    acc_d = acc_q + p_ext;
      svfm_pkg::PH_DRAIN: acc_d = acc_q + (p_ext <<< svfm_pkg::ChunkW);
      svfm_pkg::PH_WB:    acc_d = acc_q;
      default:            acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (phase_i == svfm_pkg::PH_LO || phase_i == svfm_pkg::PH_HI) begin
      p_q <= prod;
    end
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

### rtl/core/svfm_ctrl.sv
// Sequencer: steps through the eight products, four phases each.
module svfm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 out_free_i,
  output svfm_pkg::seq_ctrl_t  ctrl_o
);

  svfm_pkg::fsm_e   state_d, state_q;
  svfm_pkg::op_e    op_d, op_q;
  svfm_pkg::phase_e phase_d, phase_q;
  logic             done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svfm_pkg::ST_IDLE;
      op_q    <= svfm_pkg::OP_CLIP;
      phase_q <= svfm_pkg::PH_LO;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    phase_d = phase_q;
    done    = 1'b0;
    case (state_q)
      svfm_pkg::ST_IDLE: begin
        if (s_valid_i) begin
          state_d = svfm_pkg::ST_RUN;
          op_d    = svfm_pkg::OP_CLIP;
          phase_d = svfm_pkg::PH_LO;
        end
      end
      svfm_pkg::ST_RUN: begin
        case (phase_q)
          svfm_pkg::PH_LO:    phase_d = svfm_pkg::PH_HI;
          svfm_pkg::PH_HI:    phase_d = svfm_pkg::PH_DRAIN;
          svfm_pkg::PH_DRAIN: phase_d = svfm_pkg::PH_WB;
          svfm_pkg::PH_WB: begin
            if (op_q == svfm_pkg::OP_MIX_HIGH) begin
              // hold the last write-back until the output slot is free
              if (out_free_i) begin
                done    = 1'b1;
                state_d = svfm_pkg::ST_IDLE;
              end
            end else begin
              op_d    = svfm_pkg::op_e'(op_q + 3'd1);
              phase_d = svfm_pkg::PH_LO;
            end
          end
          default: phase_d = svfm_pkg::PH_LO;
        endcase
      end
      default: state_d = svfm_pkg::ST_IDLE;
    endcase
  end

  assign ctrl_o.ready = (state_q == svfm_pkg::ST_IDLE);
  assign ctrl_o.busy  = (state_q == svfm_pkg::ST_RUN);
  assign ctrl_o.op    = op_q;
  assign ctrl_o.phase = phase_q;
  assign ctrl_o.done  = done;

endmodule

### bench/svf_check_pkg.sv
package svf_check_pkg;

  import svfm_pkg::*;

  localparam int NumChannels = 2;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               channel;
  } svf_result_t;

  // Tracks the filter settings and integrators and predicts each output sample
  class svf_scoreboard;
    longint cutoff, damp, norm;
    longint mix_lo, mix_bp, mix_hp;
    longint knee, slope;
    longint band_int [NumChannels];
    longint low_int  [NumChannels];
    svf_result_t awaited [$];
    int unsigned errors;

    function new();
      cutoff = CutoffReset;
      damp   = DampReset;
      norm   = NormReset;
      mix_lo = $signed(MixLowReset);
      mix_bp = $signed(MixBandReset);
      mix_hp = $signed(MixHighReset);
      knee   = ThReset;
      slope  = CgReset;
      foreach (band_int[i]) begin
        band_int[i] = 0;
        low_int[i]  = 0;
      end
      errors = 0;
    endfunction

    // Divide by 2^s, rounding half up
    function longint rescale(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clamp(longint x, int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] data);
      case (index)
        REG_CUTOFF_GAIN:    cutoff = data;
        REG_DAMPING:        damp   = data;
        REG_NORM_GAIN:      norm   = data;
        REG_MIX_LOW:        mix_lo = $signed(data[MixW-1:0]);
        REG_MIX_BAND:       mix_bp = $signed(data[MixW-1:0]);
        REG_MIX_HIGH:       mix_hp = $signed(data[MixW-1:0]);
        REG_CLIP_THRESHOLD: knee   = data[ThW-1:0];
        REG_CLIP_GAIN:      slope  = data[CgW-1:0];
        default: ;
      endcase
    endfunction

    // Run one sample through clip, filter and mix; queue the output it must produce
    function void take_sample(logic [SampleW-1:0] raw, logic ch);
      longint x, v0, v1, v2, hp, acc, ic1, ic2;
      int idx;
      svf_result_t r;
      idx = int'(ch) % NumChannels;
      x   = $signed(raw);
      ic1 = band_int[idx];
      ic2 = low_int[idx];
      if (x > knee) begin
        v0 = knee + rescale((x - knee) * slope, 16);
      end else if (x < -knee) begin
        v0 = -knee + rescale((x + knee) * slope, 16);
      end else begin
        v0 = x;
      end
      v0  = clamp(v0, 24);
      acc = ic1 + rescale(cutoff * (v0 - ic2), 20);
      v1  = clamp(rescale(norm * acc, 22), 32);
      v2  = clamp(ic2 + rescale(cutoff * v1, 20), 32);
      hp  = v0 - rescale(damp * v1, 22) - v2;
      band_int[idx] = clamp(2 * v1 - ic1, 32);
      low_int[idx]  = clamp(2 * v2 - ic2, 32);
      acc = mix_lo * v2 + mix_bp * v1 + mix_hp * hp;
      acc = clamp(rescale(acc, 14), 24);
      r.sample  = acc[SampleW-1:0];
      r.channel = ch;
      awaited.push_back(r);
    endfunction

    function void check_output(logic [SampleW-1:0] sample, logic ch);
      svf_result_t e;
      if (awaited.size() == 0) begin
        $error("svf: output with no sample pending, sample_out %0d", $signed(sample));
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (sample !== e.sample) begin
        $error("svf: sample_out expected %0d, got %0d", $signed(e.sample), $signed(sample));
        errors++;
      end
      if (ch !== e.channel) begin
        $error("svf: channel_out expected %0d, got %0d", e.channel, ch);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

endpackage

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svfm_pkg::*;
  import svf_check_pkg::*;

  // Slowest legal run: ~700 samples, each a full busy sequence plus a long output
  // stall and a sender gap, plus drains between phases; take it several times over.
  localparam int unsigned CycleLimit = 600000;
  localparam int          LatencyCycles = 40;
  localparam logic [CfgIdxW-1:0] FirstUnmapped = CfgIdxW'(REG_CLIP_GAIN + 1);
  localparam logic [SampleW-1:0] SampleMax = 24'h7FFFFF;
  localparam logic [SampleW-1:0] SampleMin = 24'h800000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata = '0;  // [23:0] sample_in
  logic                s_axis_tuser = 1'b0;  // [0] channel_num
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;  // [23:0] sample_out
  logic                m_axis_tuser;  // [0] channel_out

  svf_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;

  state_variable_filter_morph #(
    .NUM_CHANNELS(NumChannels)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the outputs never drain
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Receiver: switch among stall patterns at random intervals; mode 0
  // leaves stretches with no backpressure at all.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    case (rx_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = 1'($urandom_range(0, 1));
      2: m_axis_tready = (cycle_count % 7) < 3;
      default: m_axis_tready = ($urandom_range(0, 15) == 0);
    endcase
  end

  // Check every output transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_output(m_axis_tdata, m_axis_tuser);
    end
  end

  // Write one register; call only while nothing is in flight
  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(index, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Offer one sample; hold tvalid through a burst, then drop it for a random gap
  task automatic send_sample(input logic [SampleW-1:0] s, input logic ch);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = s;
    s_axis_tuser  = ch;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_sample(s, ch);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = 24'($urandom);
      s_axis_tuser  = 1'($urandom);
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
    end
  endtask

  // Drop tvalid, wait for every predicted output, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly full-scale noise, some quiet signal, rails and the clip knee
  function automatic logic [SampleW-1:0] pick_sample();
    int unsigned sel;
    longint      v;
    sel = $urandom_range(0, 19);
    if (sel < 11) begin
      v = $urandom;
    end else if (sel < 16) begin
      v = longint'($urandom_range(0, 131071)) - 65536;
    end else if (sel < 18) begin
      v = $urandom_range(0, 1) ? $signed(SampleMax) : $signed(SampleMin);
    end else begin
      v = sb.knee + longint'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v[SampleW-1:0];
  endfunction

  // Load a full register set: rails, zeros, raw noise or a playable filter.
  // Fill the bits above each field with junk so the masking gets exercised.
  task automatic load_settings(input int kind);
    logic [CoefW-1:0] g, k, nrm;
    logic [MixW-1:0]  mlo, mbp, mhp;
    logic [ThW-1:0]   th;
    logic [CgW-1:0]   cg;
    real              gr, kr;
    case (kind)
      0: begin
        g = '1; k = '1; nrm = '1;
        mlo = 16'h7FFF; mbp = 16'h8000; mhp = 16'h7FFF;
        th = '1; cg = '1;
      end
      1: begin
        g = '0; k = '0; nrm = '0;
        mlo = 16'h8000; mbp = 16'h7FFF; mhp = 16'h8000;
        th = '0; cg = '0;
      end
      2: begin
        g = CoefW'($urandom); k = CoefW'($urandom); nrm = CoefW'($urandom);
        mlo = MixW'($urandom); mbp = MixW'($urandom); mhp = MixW'($urandom);
        th = ThW'($urandom); cg = CgW'($urandom);
      end
      default: begin
        g   = CoefW'($urandom_range(1 << 14, 1 << 21));
        k   = CoefW'($urandom_range(1 << 20, 3 << 22));
        gr  = real'(g) / 1048576.0;
        kr  = real'(k) / 4194304.0;
        nrm = CoefW'(int'(4194304.0 / (1.0 + gr * (gr + kr))));
        mlo = MixW'(int'($urandom_range(0, 32767)) - 16384);
        mbp = MixW'(int'($urandom_range(0, 32767)) - 16384);
        mhp = MixW'(int'($urandom_range(0, 32767)) - 16384);
        th  = ThW'($urandom_range(0, 8388607));
        cg  = CgW'($urandom_range(0, 80000));
      end
    endcase
    write_reg(REG_CUTOFF_GAIN, g);
    write_reg(REG_DAMPING, k);
    write_reg(REG_NORM_GAIN, nrm);
    write_reg(REG_MIX_LOW, {8'($urandom), mlo});
    write_reg(REG_MIX_BAND, {8'($urandom), mbp});
    write_reg(REG_MIX_HIGH, {8'($urandom), mhp});
    write_reg(REG_CLIP_THRESHOLD, {1'($urandom), th});
    write_reg(REG_CLIP_GAIN, {7'($urandom), cg});
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CfgIdxW'($urandom_range(FirstUnmapped, 15)), CfgDataW'($urandom));
    end
  endtask

  initial begin
    int kind;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset settings: rails, zero and -1 on both channels
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b0);
    send_sample('0, 1'b1);
    send_sample('1, 1'b1);
    send_sample(SampleMax, 1'b1);
    send_sample(24'd1, 1'b0);
    drain();

    // Low knee with slope above unity: on the knee, just past it on both
    // sides, and rails that push the clipped value into saturation
    write_reg(REG_CLIP_THRESHOLD, 24'd1000);
    write_reg(REG_CLIP_GAIN, 24'h01FFFF);
    write_reg(REG_MIX_BAND, 24'h008000);
    write_reg(REG_MIX_HIGH, 24'h007FFF);
    send_sample(24'd1000, 1'b0);
    send_sample(24'd1001, 1'b0);
    send_sample(-24'sd1000, 1'b1);
    send_sample(-24'sd1001, 1'b1);
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b1);
    drain();

    // Zero knee and zero slope: everything clips to silence
    write_reg(REG_CLIP_THRESHOLD, 24'd0);
    write_reg(REG_CLIP_GAIN, 24'd0);
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b1);
    send_sample(24'h123456, 1'b0);
    drain();

    // Largest gains with full-scale drive: integrators and mix saturate.
    // Drop a couple of writes to unmapped indices on the way.
    write_reg(FirstUnmapped, 24'hFFFFFF);
    write_reg(4'd15, 24'h000000);
    write_reg(REG_CUTOFF_GAIN, 24'hFFFFFF);
    write_reg(REG_DAMPING, 24'd0);
    write_reg(REG_NORM_GAIN, 24'hFFFFFF);
    write_reg(REG_CLIP_THRESHOLD, 24'h7FFFFF);
    write_reg(REG_CLIP_GAIN, 24'd65536);
    write_reg(REG_MIX_LOW, 24'h007FFF);
    repeat (4) begin
      send_sample(SampleMax, 1'b0);
      send_sample(SampleMin, 1'b1);
    end
    drain();

    // Random phases: rails, zeros and raw noise first, then mostly playable
    // filters, each with a fresh register set and ~80 samples
    for (int p = 0; p < 8; p++) begin
      kind = (p < 3) ? p : int'($urandom_range(2, 5));
      load_settings(kind);
      repeat (80) send_sample(pick_sample(), 1'($urandom_range(0, 1)));
      drain();
    end

    s_axis_tvalid = 1'b0;
    repeat (LatencyCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/svfm_pkg.sv
rtl/core/svfm_mac.sv
rtl/core/svfm_ctrl.sv
rtl/core/state_variable_filter_morph.sv
bench/svf_check_pkg.sv
bench/tb.sv
